### sv/scf_pkg.sv
package scf_pkg;

  localparam int VelWidth   = 16;
  localparam int DzWidth    = 16;
  localparam int WeightBits = 16;
  localparam int OutWidth   = 32;

  // wide enough for any negated product of two velocity terms
  localparam int ProdW      = 2 * VelWidth + 2;
  // common width for saturation compares, above ProdW for any VelWidth up to 38
  localparam int WideW      = 80;
  // averaged w squared clamps once |w_here + w_below| reaches 2^SqLimitLog
  localparam int SqLimitLog = 20;
  // one quotient bit per divider stage, the integer bit included
  localparam int DivSteps   = WeightBits + 1;

  typedef enum logic [1:0] {
    PosBottom    = 2'd0,
    PosGeneral   = 2'd1,
    PosSecondTop = 2'd2,
    PosTop       = 2'd3
  } scf_pos_e;

  typedef struct packed {
    scf_pos_e                    position;
    logic signed [VelWidth-1:0] u_here;
    logic signed [VelWidth-1:0] v_here;
    logic signed [VelWidth-1:0] w_here;
    logic signed [VelWidth-1:0] u_above;
    logic signed [VelWidth-1:0] v_above;
    logic signed [VelWidth-1:0] w_below;
    logic        [DzWidth-1:0]  dz_below;
    logic        [DzWidth-1:0]  dz_here;
  } scf_in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] flux_xx;
    logic signed [OutWidth-1:0] flux_xy;
    logic signed [OutWidth-1:0] flux_yy;
    logic signed [OutWidth-1:0] flux_xz;
    logic signed [OutWidth-1:0] flux_yz;
    logic signed [OutWidth-1:0] flux_zz;
    logic                       xz_valid;
  } scf_out_t;

  // clamp a wide signed value to the output range
  function automatic logic signed [OutWidth-1:0] sat_out(logic signed [ProdW-1:0] x);
    logic signed [WideW-1:0] xw;
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    xw = WideW'(x);
    hi = WideW'(signed'({1'b0, {(OutWidth-1){1'b1}}}));
    lo = WideW'(signed'({1'b1, {(OutWidth-1){1'b0}}}));
    if (xw > hi) begin
      sat_out = {1'b0, {(OutWidth-1){1'b1}}};
    end else if (xw < lo) begin
      sat_out = {1'b1, {(OutWidth-1){1'b0}}};
    end else begin
      sat_out = xw[OutWidth-1:0];
    end
  endfunction

endpackage

### sv/scf_div.sv
// Pipelined restoring divider for the interpolation weight:
// quot = floor(num * 2^WeightBits / den), with num <= den; 0 when den is 0.
module scf_div import scf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DzWidth-1:0] num_i,
  input  logic [DzWidth:0]   den_i,
  output logic               valid_o,
  output logic [WeightBits:0] quot_o
);

  logic [DzWidth+1:0]  rem_q  [DivSteps];
  logic [WeightBits:0] quo_q  [DivSteps];
  logic [DzWidth:0]    den_q  [DivSteps];
  logic                zero_q [DivSteps];
  logic                vld_q  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [DzWidth+1:0]  part;
    logic [DzWidth:0]    den;
    logic [WeightBits:0] quo_in;
    logic                zero;
    logic                vld;
    logic                hit;
    logic [DzWidth+1:0]  rem_d;
    logic [WeightBits:0] quo_d;

    if (k == 0) begin : g_first
      assign part   = {2'b00, num_i};
      assign den    = den_i;
      assign quo_in = '0;
      assign zero   = (den_i == '0);
      assign vld    = valid_i;
    end else begin : g_rest
      assign part   = {rem_q[k-1][DzWidth:0], 1'b0};
      assign den    = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign zero   = zero_q[k-1];
      assign vld    = vld_q[k-1];
    end

    always_comb begin
      hit   = (part >= {1'b0, den});
      rem_d = hit ? (part - {1'b0, den}) : part;
      quo_d = quo_in;
      quo_d[WeightBits-k] = hit;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      quo_q[k]  <= quo_d;
      den_q[k]  <= den;
      zero_q[k] <= zero;
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quot_o  = zero_q[DivSteps-1] ? '0 : quo_q[DivSteps-1];

endmodule

### sv/staggered_convection_flux.sv
// Convective momentum flux at one point of a vertically staggered mesh.
//
// Input channel: a beat is taken at each rising edge with start_i high and
// busy_o low. busy_o is held low, so a new grid point may enter every cycle.
// Output channel: valid_o is high for exactly one cycle with res_o holding
// the six flux terms and xz_valid; the receiver has no way to hold it off.
//
// From the accepting edge to the strobe, a beat passes 1 input register,
// 17 divider stages for the weight (one quotient bit per stage), then
// three arithmetic stages (products, rounding and saturation, vertical
// products). Throughput is one beat per cycle; the divider pipeline sets
// the latency, not the rate.
//
// Results leave in the order the beats entered. Reset clears only the
// valid bits of the pipeline; beats in flight at reset are dropped. Since
// nothing can stall the output, the pipeline never holds.
module staggered_convection_flux import scf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  scf_in_t  in_i,
  output logic     valid_o,
  output scf_out_t res_o
);

  localparam int DiffW   = VelWidth + 1;
  localparam int BetaW   = WeightBits + 2;
  localparam int PW      = DiffW + BetaW;
  localparam int InterpW = VelWidth + WeightBits + 4;
  localparam int SqW     = 2 * VelWidth + 2;

  assign busy_o = 1'b0;

  // ---------------- input register ----------------
  logic             s0_vld_q;
  scf_in_t          s0_q;
  logic [DzWidth:0] s0_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q     <= in_i;
    s0_sum_q <= {1'b0, in_i.dz_below} + {1'b0, in_i.dz_here};
  end

  // ---------------- weight divider, payload rides alongside ----------------
  logic                div_vld;
  logic [WeightBits:0] beta;
  scf_in_t             dly_q [DivSteps];

  scf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .num_i   (s0_q.dz_below),
    .den_i   (s0_sum_q),
    .valid_o (div_vld),
    .quot_o  (beta)
  );

  always_ff @(posedge clk_i) begin
    dly_q[0] <= s0_q;
    for (int k = 1; k < DivSteps; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  scf_in_t d_in;
  assign d_in = dly_q[DivSteps-1];

  // ---------------- stage 1: products ----------------
  logic signed [DiffW-1:0]    du, dv, wsum;
  logic signed [BetaW-1:0]    beta_s;
  logic        [DiffW-1:0]    wmag;
  logic                       avg;

  always_comb begin
    du     = DiffW'(d_in.u_above) - DiffW'(d_in.u_here);
    dv     = DiffW'(d_in.v_above) - DiffW'(d_in.v_here);
    beta_s = signed'({1'b0, beta});
    // bottom and top square a single w; the inner layers average two
    case (d_in.position)
      PosBottom: begin
        wsum = DiffW'(d_in.w_here);
        avg  = 1'b0;
      end
      PosTop: begin
        wsum = DiffW'(d_in.w_below);
        avg  = 1'b0;
      end
      default: begin
        wsum = DiffW'(d_in.w_here) + DiffW'(d_in.w_below);
        avg  = 1'b1;
      end
    endcase
    wmag = wsum[DiffW-1] ? DiffW'(-wsum) : DiffW'(wsum);
  end

  logic                         s1_vld_q;
  scf_pos_e                     s1_pos_q;
  logic signed [VelWidth-1:0]   s1_u_q, s1_v_q, s1_w_q, s1_ua_q, s1_va_q;
  logic signed [2*VelWidth-1:0] s1_uu_q, s1_uv_q, s1_vv_q;
  logic signed [PW-1:0]         s1_pu_q, s1_pv_q;
  logic        [SqW-1:0]        s1_sq_q;
  logic                         s1_avg_q, s1_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pos_q <= d_in.position;
    s1_u_q   <= d_in.u_here;
    s1_v_q   <= d_in.v_here;
    s1_w_q   <= d_in.w_here;
    s1_ua_q  <= d_in.u_above;
    s1_va_q  <= d_in.v_above;
    s1_uu_q  <= d_in.u_here * d_in.u_here;
    s1_uv_q  <= d_in.u_here * d_in.v_here;
    s1_vv_q  <= d_in.v_here * d_in.v_here;
    s1_pu_q  <= du * beta_s;
    s1_pv_q  <= dv * beta_s;
    s1_sq_q  <= SqW'(wmag) * SqW'(wmag);
    s1_avg_q <= avg;
    s1_lim_q <= avg && (WideW'(wmag) >= (WideW'(1) << SqLimitLog));
  end

  // ---------------- stage 2: interpolate, round, saturate ----------------
  logic signed [InterpW-1:0]  xu, xv;
  logic signed [VelWidth-1:0] ui, vi;
  logic        [SqW-1:0]      zq;
  logic signed [OutWidth-1:0] zz;

  always_comb begin
    // ties go toward plus infinity: add half an LSB, then floor
    xu = (InterpW'(s1_u_q) <<< WeightBits) + InterpW'(s1_pu_q)
         + (InterpW'(1) <<< (WeightBits - 1));
    xv = (InterpW'(s1_v_q) <<< WeightBits) + InterpW'(s1_pv_q)
         + (InterpW'(1) <<< (WeightBits - 1));
    case (s1_pos_q)
      PosGeneral: begin
        ui = xu[WeightBits +: VelWidth];
        vi = xv[WeightBits +: VelWidth];
      end
      PosSecondTop: begin
        ui = s1_ua_q;
        vi = s1_va_q;
      end
      default: begin
        ui = s1_u_q;
        vi = s1_v_q;
      end
    endcase
    zq = s1_avg_q ? ((s1_sq_q + SqW'(2)) >> 2) : s1_sq_q;
    if (s1_lim_q) begin
      zz = {1'b1, {(OutWidth-1){1'b0}}};
    end else begin
      zz = sat_out(-signed'(ProdW'(zq)));
    end
  end

  logic                       s2_vld_q;
  logic                       s2_xzv_q;
  logic signed [VelWidth-1:0] s2_w_q, s2_ui_q, s2_vi_q;
  logic signed [OutWidth-1:0] s2_xx_q, s2_xy_q, s2_yy_q, s2_zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_xzv_q <= (s1_pos_q != PosTop);
    s2_w_q   <= s1_w_q;
    s2_ui_q  <= ui;
    s2_vi_q  <= vi;
    s2_xx_q  <= sat_out(-ProdW'(s1_uu_q));
    s2_xy_q  <= sat_out(-ProdW'(s1_uv_q));
    s2_yy_q  <= sat_out(-ProdW'(s1_vv_q));
    s2_zz_q  <= zz;
  end

  // ---------------- stage 3: vertical products, output register ----------------
  logic signed [2*VelWidth-1:0] wu, wv;
  assign wu = s2_w_q * s2_ui_q;
  assign wv = s2_w_q * s2_vi_q;

  logic     out_vld_q;
  scf_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.flux_xx  <= s2_xx_q;
    out_q.flux_xy  <= s2_xy_q;
    out_q.flux_yy  <= s2_yy_q;
    out_q.flux_xz  <= s2_xzv_q ? sat_out(-ProdW'(wu)) : '0;
    out_q.flux_yz  <= s2_xzv_q ? sat_out(-ProdW'(wv)) : '0;
    out_q.flux_zz  <= s2_zz_q;
    out_q.xz_valid <= s2_xzv_q;
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_q;

endmodule
